// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, opcodes and inter-module structs of the pagerank push scatter
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    // field widths
    localparam int unsigned OPC_W  = 2;
    localparam int unsigned RANK_W = 32;
    localparam int unsigned DEG_W  = 17;
    localparam int unsigned IDX_W  = 16;
    localparam int unsigned ACC_W  = 40;

    // vertex count handling
    localparam int unsigned VERTICES_DEF  = 65536;
    localparam int unsigned MEM_DEPTH_MAX = 65536;
    localparam int unsigned LIM_W         = 25;

    // word opcodes
    typedef enum logic [OPC_W-1:0] {
        OP_VERTEX = 2'd0,
        OP_EDGE   = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    // request into the accumulator memory
    typedef struct packed {
        logic              valid;
        logic              is_read;
        logic [IDX_W-1:0]  index;
        logic [RANK_W-1:0] share;
    } t_acc_req;

    // read response out of the accumulator memory
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] index;
        logic [ACC_W-1:0] value;
    } t_acc_rsp;

    // accumulator memory status
    typedef struct packed {
        logic clearing;
        logic read_pending;
    } t_acc_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_if.sv =====
// ----------------------------------------------------------------------------
// pps_if
// Valid/ready channels carrying input words and read result words
// ----------------------------------------------------------------------------
`default_nettype none

interface pps_in_if;
    import pps_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [RANK_W-1:0] rank_value;
    logic [DEG_W-1:0]  out_degree;
    logic [IDX_W-1:0]  target_index;

    modport source (output valid, output opcode, output rank_value,
                    output out_degree, output target_index, input ready);
    modport sink   (input valid, input opcode, input rank_value,
                    input out_degree, input target_index, output ready);
endinterface

interface pps_out_if;
    import pps_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] read_index;
    logic [ACC_W-1:0] read_value;

    modport source (output valid, output read_index, output read_value, input ready);
    modport sink   (input valid, input read_index, input read_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pps_div.sv =====
// ----------------------------------------------------------------------------
// pps_div
// Shift-subtract divider, one quotient bit per cycle, for the vertex share
// ----------------------------------------------------------------------------
`default_nettype none

module pps_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [pps_pkg::RANK_W-1:0] i_dividend,
    input  wire logic [pps_pkg::DEG_W-1:0]  i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [pps_pkg::RANK_W-1:0]     o_quot
);
    import pps_pkg::*;

    localparam int unsigned CNT_W = $clog2(RANK_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RANK_W-1:0] r_dvd, n_dvd;
    logic [DEG_W-1:0]  r_dsr, n_dsr;
    logic [DEG_W-1:0]  r_rem, n_rem;
    logic [DEG_W:0]    rem_shift;
    logic [DEG_W+1:0]  diff;
    logic              ge;

    // one restoring step
    always_comb begin
        rem_shift = {r_rem, r_dvd[RANK_W-1]};
        diff      = {1'b0, rem_shift} - {2'b00, r_dsr};
        ge        = ~diff[DEG_W+1];
    end

    // next state of the iteration
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(RANK_W - 1);
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_dvd = {r_dvd[RANK_W-2:0], ge};
            n_rem = ge ? diff[DEG_W-1:0] : rem_shift[DEG_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

`default_nettype wire

// ===== hw/rtl/pps_acc_mem.sv =====
// ----------------------------------------------------------------------------
// pps_acc_mem
// Accumulator memory with read-modify-write pipeline, forwarding and clearing
// ----------------------------------------------------------------------------
`default_nettype none

module pps_acc_mem #(
    parameter int unsigned VERTICES = pps_pkg::VERTICES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pps_pkg::t_acc_req  i_req,
    output pps_pkg::t_acc_rsp       o_rsp,
    output pps_pkg::t_acc_stat      o_stat
);
    import pps_pkg::*;

    localparam int unsigned DEPTH  = (VERTICES < MEM_DEPTH_MAX) ? VERTICES : MEM_DEPTH_MAX;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam logic [LIM_W-1:0]  VLIM    = LIM_W'(VERTICES);
    localparam logic [ACC_W-1:0]  ACC_MAX = '1;

    logic [ACC_W-1:0] mem [DEPTH];

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_s1_valid;
    logic              r_s1_read;
    logic              r_s1_ok;
    logic [IDX_W-1:0]  r_s1_index;
    logic [RANK_W-1:0] r_s1_share;
    logic [ACC_W-1:0]  r_rd_data;
    logic              r_fwd_hit;
    logic [ACC_W-1:0]  r_fwd_data;

    logic              req_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] s1_addr;
    logic [ACC_W-1:0]  old_val;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  upd_val;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ACC_W-1:0]  wr_data;

    // address decode and range check
    assign req_ok  = LIM_W'(i_req.index) < VLIM;
    assign rd_addr = i_req.index[ADDR_W-1:0];
    assign s1_addr = r_s1_index[ADDR_W-1:0];

    // modify stage: saturating add for edges, clear for reads
    always_comb begin
        old_val = r_fwd_hit ? r_fwd_data : r_rd_data;
        sum     = {1'b0, old_val} + {(ACC_W+1-RANK_W)'(0), r_s1_share};
        if (r_s1_read) begin
            upd_val = '0;
        end else begin
            upd_val = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
        end
    end

    // write port select: clearing pass or write back
    always_comb begin
        wr_en   = r_clearing || (r_s1_valid && r_s1_ok);
        wr_addr = r_clearing ? r_clr_addr : s1_addr;
        wr_data = r_clearing ? '0 : upd_val;
    end

    // memory array
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // forward a write to the same entry read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= r_s1_valid && r_s1_ok && i_req.valid && (rd_addr == s1_addr);
        end
        r_fwd_data <= upd_val;
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // modify stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
        end
        r_s1_read  <= i_req.is_read;
        r_s1_ok    <= req_ok;
        r_s1_index <= i_req.index;
        r_s1_share <= i_req.share;
    end

    // read response
    always_comb begin
        o_rsp.valid = r_s1_valid && r_s1_read;
        o_rsp.index = r_s1_index;
        o_rsp.value = r_s1_ok ? old_val : '0;
    end

    assign o_stat.clearing     = r_clearing;
    assign o_stat.read_pending = r_s1_valid && r_s1_read;

endmodule

`default_nettype wire

// ===== hw/rtl/pagerank_push_scatter_top.sv =====
// ----------------------------------------------------------------------------
// pagerank_push_scatter_top
// Push-style PageRank scatter: vertex share, accumulate edges, read and clear
// ----------------------------------------------------------------------------
// Edge and read words are taken one per cycle unless the input is stalled,
// and go through a two-stage read-modify-write on an accumulator memory with
// one read and one write port, so an edge to the same destination in the next
// cycle is forwarded rather than stalled. A vertex word with nonzero degree
// holds the input while the shift-subtract divider produces the 32-bit share;
// a zero degree sets a zero share without the divider. Read results go into a
// two-word output queue; the input stalls for any word while a further read
// could not find room there. After reset the input is held while the memory
// is cleared.
`default_nettype none

module pagerank_push_scatter_top #(
    parameter int unsigned VERTICES = pps_pkg::VERTICES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pps_in_if.sink     i_in,
    pps_out_if.source  o_out
);
    import pps_pkg::*;

    logic [RANK_W-1:0] r_share;
    logic [RANK_W-1:0] cur_share;
    logic              in_acc;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [RANK_W-1:0] div_quot;
    t_acc_req          acc_req;
    t_acc_rsp          acc_rsp;
    t_acc_stat         acc_stat;
    logic              room;

    // output queue
    logic [IDX_W-1:0]  r_q_idx [2];
    logic [ACC_W-1:0]  r_q_val [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_cnt;
    logic              q_push;
    logic              q_pop;

    // input handshake
    always_comb begin
        room       = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !acc_stat.read_pending);
        i_in.ready = !acc_stat.clearing && !div_busy && room;
        in_acc     = i_in.valid && i_in.ready;
    end

    // share of the current source vertex
    assign cur_share = div_done ? div_quot : r_share;
    assign div_start = in_acc && (i_in.opcode == OP_VERTEX) && (i_in.out_degree != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_share <= '0;
        end else if (in_acc && (i_in.opcode == OP_VERTEX)) begin
            r_share <= '0;
        end else if (div_done) begin
            r_share <= div_quot;
        end
    end

    pps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.rank_value),
        .i_divisor  (i_in.out_degree),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // edge and read words to the accumulator memory
    always_comb begin
        acc_req.valid   = in_acc && ((i_in.opcode == OP_EDGE) || (i_in.opcode == OP_READ));
        acc_req.is_read = i_in.opcode == OP_READ;
        acc_req.index   = i_in.target_index;
        acc_req.share   = cur_share;
    end

    pps_acc_mem #(
        .VERTICES (VERTICES)
    ) u_acc_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (acc_req),
        .o_rsp   (acc_rsp),
        .o_stat  (acc_stat)
    );

    // result queue
    assign q_push = acc_rsp.valid;
    assign q_pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (q_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(q_push) - 2'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_idx[r_wr_ptr] <= acc_rsp.index;
            r_q_val[r_wr_ptr] <= acc_rsp.value;
        end
    end

    assign o_out.valid      = r_cnt != 2'd0;
    assign o_out.read_index = r_q_idx[r_rd_ptr];
    assign o_out.read_value = r_q_val[r_rd_ptr];

    // checks
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_stat.clearing |-> !i_in.ready)
        else $error("input accepted during clearing pass");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) || (r_cnt == 2'd1) || (r_cnt == 2'd2))
        else $error("result queue count out of range");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && (r_cnt == 2'd2)) |-> q_pop)
        else $error("result queue overflow");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.opcode == OP_READ)) |=> acc_rsp.valid)
        else $error("read word produced no result");

    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !i_in.ready)
        else $error("input accepted while share is computed");

endmodule

`default_nettype wire
